// File: sv/rtnh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_pkg
// Shared types and codes of the route table next hop resolver.
// ----------------------------------------------------------------------------
package rtnh_pkg;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_RESOLVE = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_BAD_DIST  = 3'd4;

  typedef struct packed {
    logic [31:0] nxt;
    logic [3:0]  itf;
    logic [7:0]  metric;
  } entry_t;

  // search beat that travels down the cell row
  typedef struct packed {
    logic        vld;
    logic [31:0] key;
    logic        hit;
    entry_t      data;
    logic        free;
  } tok_t;

  typedef struct packed {
    logic wr;
    logic del;
    logic clr_all;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/rtnh_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_cell
// One table slot. Matches the passing search beat against its entry, marks
// the first free slot, and takes writes and removals addressed to its own index.
// ----------------------------------------------------------------------------
module rtnh_cell #(
  parameter int SLOT_W = 6,
  parameter int IDX    = 0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire rtnh_pkg::tok_t      tok_in,
  input  wire  [SLOT_W-1:0]        hit_slot_in,
  input  wire  [SLOT_W-1:0]        free_slot_in,
  output rtnh_pkg::tok_t           tok_out,
  output logic [SLOT_W-1:0]        hit_slot_out,
  output logic [SLOT_W-1:0]        free_slot_out,
  input  wire rtnh_pkg::cmd_t      cmd,
  input  wire  [SLOT_W-1:0]        cmd_slot,
  input  wire  [31:0]              wr_dest,
  input  wire rtnh_pkg::entry_t    wr_data
);
  import rtnh_pkg::*;

  logic        valid_r;
  logic [31:0] dest_r;
  entry_t      data_r;
  tok_t        tok_r, tok_nxt;
  logic [SLOT_W-1:0] hs_r, hs_nxt, fs_r, fs_nxt;
  logic        mine;

  assign mine = (cmd_slot == SLOT_W'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clr_all) begin
      valid_r <= 1'b0;
    end else if (cmd.wr && mine) begin
      valid_r <= 1'b1;
    end else if (cmd.del && mine) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && mine) begin
      dest_r <= wr_dest;
      data_r <= wr_data;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    hs_nxt  = hit_slot_in;
    fs_nxt  = free_slot_in;
    if (!tok_in.hit && valid_r && dest_r == tok_in.key) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.data = data_r;
      hs_nxt       = SLOT_W'(IDX);
    end
    if (!tok_in.free && !valid_r) begin
      tok_nxt.free = 1'b1;
      fs_nxt       = SLOT_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.key  <= tok_nxt.key;
    tok_r.hit  <= tok_nxt.hit;
    tok_r.data <= tok_nxt.data;
    tok_r.free <= tok_nxt.free;
    hs_r       <= hs_nxt;
    fs_r       <= fs_nxt;
  end

  assign tok_out       = tok_r;
  assign hit_slot_out  = hs_r;
  assign free_slot_out = fs_r;

endmodule
`default_nettype wire

// File: sv/route_table_next_hop_resolver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// route_table_next_hop_resolver
// Route table of TABLE_DEPTH slots kept in a row of cells, with a resolver
// that follows next hops through the table.
// ----------------------------------------------------------------------------
// Usage: one item enters on the in_ channel (valid/stall), one result beat
// leaves on the out_ channel for every item. in_stall is high while an item
// is at work; a new item is taken while the previous result still waits.
// Every table search is one beat sent down the row of cells, one cell per
// cycle, through every cell of the row.
// Steps per item: add, remove and lookup go through launch, scan and finish;
// add with zero distance, clear and unknown codes go straight to finish.
// Resolve starts in step and runs launch, scan and step again for each of
// H hops, H at most TABLE_DEPTH, then finish. The result beat shows as the
// block turns idle again; the cell row serves one search at a time.
// Reset clears all valid marks at once; the table is empty right after it.
// When the receiver stalls, the result holds on out_ and a finished item
// waits until the output register is free.
// ----------------------------------------------------------------------------
module route_table_next_hop_resolver #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_operation,
  input  wire  [31:0] in_dest_addr,
  input  wire  [31:0] in_next_addr,
  input  wire  [3:0]  in_interface_index,
  input  wire  [7:0]  in_distance,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_route_dest,
  output logic [31:0] out_route_next,
  output logic [3:0]  out_route_interface,
  output logic [7:0]  out_route_distance
);
  import rtnh_pkg::*;

  localparam int SW = $clog2(TABLE_DEPTH);
  localparam int HW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] cd_r, cd_nxt, cn_r, cn_nxt;
  logic [3:0]  ci_r, ci_nxt;
  logic [7:0]  cx_r, cx_nxt;
  logic [HW-1:0] hops_r, hops_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [2:0]  rs_r, rs_nxt;
  logic [31:0] rd_r, rd_nxt, rn_r, rn_nxt;
  logic [3:0]  ri_r, ri_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        ov_r, ov_nxt;
  logic        load;
  logic        accept;

  tok_t        tok  [0:TABLE_DEPTH];
  logic [SW-1:0] hs [0:TABLE_DEPTH];
  logic [SW-1:0] fs [0:TABLE_DEPTH];
  tok_t        tail;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign load     = (state_r == S_FIN) && (!ov_r || !out_stall);

  always_comb begin
    tok[0].vld  = (state_r == S_LAUNCH);
    tok[0].key  = (op_r == OP_RESOLVE) ? cn_r : cd_r;
    tok[0].hit  = 1'b0;
    tok[0].data = '0;
    tok[0].free = 1'b0;
    hs[0]       = '0;
    fs[0]       = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rtnh_cell #(.SLOT_W(SW), .IDX(g)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .tok_in       (tok[g]),
      .hit_slot_in  (hs[g]),
      .free_slot_in (fs[g]),
      .tok_out      (tok[g+1]),
      .hit_slot_out (hs[g+1]),
      .free_slot_out(fs[g+1]),
      .cmd          (cmd_r),
      .cmd_slot     (slot_r),
      .wr_dest      (cd_r),
      .wr_data      ({cn_r, ci_r, cx_r})
    );
  end

  assign tail = tok[TABLE_DEPTH];

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cd_nxt    = cd_r;
    cn_nxt    = cn_r;
    ci_nxt    = ci_r;
    cx_nxt    = cx_r;
    hops_nxt  = hops_r;
    cmd_nxt   = '0;
    slot_nxt  = slot_r;
    rs_nxt    = rs_r;
    rd_nxt    = rd_r;
    rn_nxt    = rn_r;
    ri_nxt    = ri_r;
    rx_nxt    = rx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_operation;
          cd_nxt   = in_dest_addr;
          cn_nxt   = in_next_addr;
          ci_nxt   = in_interface_index;
          cx_nxt   = in_distance;
          hops_nxt = '0;
          rs_nxt   = ST_OK;
          rd_nxt   = '0;
          rn_nxt   = '0;
          ri_nxt   = '0;
          rx_nxt   = '0;
          case (in_operation)
            OP_ADD: begin
              if (in_distance == 8'd0) begin
                rs_nxt    = ST_BAD_DIST;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_LAUNCH;
              end
            end
            OP_REMOVE, OP_LOOKUP: state_nxt = S_LAUNCH;
            OP_RESOLVE:           state_nxt = S_STEP;
            OP_CLEAR: begin
              cmd_nxt.clr_all = 1'b1;
              state_nxt       = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_LAUNCH: state_nxt = S_SCAN;
      S_SCAN: begin
        if (tail.vld) begin
          state_nxt = S_FIN;
          case (op_r)
            OP_ADD: begin
              if (tail.hit || tail.free) begin
                cmd_nxt.wr = 1'b1;
                slot_nxt   = tail.hit ? hs[TABLE_DEPTH] : fs[TABLE_DEPTH];
                rd_nxt     = cd_r;
                rn_nxt     = cn_r;
                ri_nxt     = ci_r;
                rx_nxt     = cx_r;
              end else begin
                rs_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (tail.hit) begin
                cmd_nxt.del = 1'b1;
                slot_nxt    = hs[TABLE_DEPTH];
              end else begin
                rs_nxt = ST_NOT_FOUND;
              end
            end
            OP_LOOKUP: begin
              if (tail.hit) begin
                rd_nxt = cd_r;
                rn_nxt = tail.data.nxt;
                ri_nxt = tail.data.itf;
                rx_nxt = tail.data.metric;
              end else begin
                rs_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              // resolve: take the entry keyed by the current next hop
              if (tail.hit) begin
                cd_nxt    = cn_r;
                cn_nxt    = tail.data.nxt;
                ci_nxt    = tail.data.itf;
                cx_nxt    = tail.data.metric;
                hops_nxt  = hops_r + HW'(1);
                state_nxt = S_STEP;
              end else begin
                rs_nxt = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      S_STEP: begin
        if (cd_r == cn_r) begin
          rd_nxt    = cd_r;
          rn_nxt    = cn_r;
          ri_nxt    = ci_r;
          rx_nxt    = cx_r;
          state_nxt = S_FIN;
        end else if (hops_r == HW'(TABLE_DEPTH)) begin
          rs_nxt    = ST_TOO_LONG;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_LAUNCH;
        end
      end
      S_FIN: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    cd_r   <= cd_nxt;
    cn_r   <= cn_nxt;
    ci_r   <= ci_nxt;
    cx_r   <= cx_nxt;
    hops_r <= hops_nxt;
    slot_r <= slot_nxt;
    rs_r   <= rs_nxt;
    rd_r   <= rd_nxt;
    rn_r   <= rn_nxt;
    ri_r   <= ri_nxt;
    rx_r   <= rx_nxt;
    if (load) begin
      out_status          <= rs_r;
      out_route_dest      <= rd_r;
      out_route_next      <= rn_r;
      out_route_interface <= ri_r;
      out_route_distance  <= rx_r;
    end
  end

  assign out_valid = ov_r;

`ifndef SYNTHESIS
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == S_SCAN)
    else $error("search beat left the row outside a scan");

  a_cmd_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r.wr || cmd_r.del || cmd_r.clr_all) |-> state_r == S_FIN)
    else $error("table command outside the finish state");

  a_hops_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> hops_r <= HW'(TABLE_DEPTH))
    else $error("resolve hop count past table depth");
`endif

endmodule
`default_nettype wire
